### rtl/core/pist_pkg.sv
// Shared types and constants of the point-in-oriented-shape test core.
// Payload structs, shape kind codes, register indexes and the sine coefficients.
// Depends on nothing.
`default_nettype none

package pist_pkg;

    typedef struct packed {
        logic        [2:0]  mode;
        logic signed [31:0] entity_x;
        logic signed [31:0] entity_y;
        logic        [15:0] entity_angle;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic        [15:0] shape_angle;
        logic signed [31:0] size_a;
        logic signed [31:0] size_b;
        logic        [15:0] entity_tag;
    } t_item_in;

    typedef struct packed {
        logic        hit;
        logic [15:0] result_tag;
    } t_res_out;

    typedef struct packed {
        logic [3:0]  index;
        logic [31:0] value;
    } t_cfg_wr;

    localparam logic [2:0] MODE_GRID   = 3'd0;
    localparam logic [2:0] MODE_BOX    = 3'd1;
    localparam logic [2:0] MODE_CIRCLE = 3'd2;
    localparam logic [2:0] MODE_CAPS   = 3'd3;
    localparam logic [2:0] MODE_IMAGE  = 3'd4;
    localparam logic [2:0] MODE_PROX   = 3'd5;

    localparam logic [3:0] REG_QUERY_X = 4'd0;
    localparam logic [3:0] REG_QUERY_Y = 4'd1;

    // sine polynomial, Q2.28
    localparam int TRIG_BITS = 28;
    localparam logic signed [63:0] S_C1 = 64'sd421657428;
    localparam logic signed [63:0] S_C3 = 64'sd173399667;
    localparam logic signed [63:0] S_C5 = 64'sd21392326;
    localparam logic signed [63:0] S_C7 = 64'sd1256751;
    localparam logic signed [63:0] S_C9 = 64'sd43069;

endpackage : pist_pkg

`default_nettype wire

### rtl/core/pist_chan_if.sv
// Valid/ready channel carrying one payload per transaction.
// Payload type is a parameter; the types come from pist_pkg.
`default_nettype none

interface pist_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface : pist_chan_if

`default_nettype wire

### rtl/core/point_in_oriented_shape_test_core.sv
// Point-in-oriented-shape test core: 43-stage pipeline, one transaction per cycle unless the pipe stalls.
// Throughput: one item per cycle; the whole pipe stalls while a result waits on the sink.
// The length is set by the 32-step restoring quotient chain of the grid kind.
// Synchronous active-low reset clears the stage valid bits and the query registers.
// Depends on pist_pkg and pist_chan_if.
`default_nettype none

module point_in_oriented_shape_test_core #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pist_chan_if.sink   i_item,
    pist_chan_if.source o_res,
    pist_chan_if.sink   i_cfg
);
    import pist_pkg::*;

    // stage map
    localparam int NS        = 43;  // last stage, also the output register
    localparam int DIV_FIRST = 11;  // first quotient step
    localparam int DIV_LAST  = 42;  // last quotient step
    localparam int QSH       = ANGLE_BITS - 2;
    localparam int XSH       = TRIG_BITS - QSH;

    localparam logic [ANGLE_BITS-1:0] QUARTER   = ANGLE_BITS'(1) << QSH;
    localparam logic [28:0]           TRIG_ONE  = 29'd1 << TRIG_BITS;
    localparam logic signed [31:0]    IMG_DEF   = 32'(100 * (1 << FRAC_BITS));
    localparam logic [63:0]           SMALL_LIM = 64'd1 << FRAC_BITS;

    // everything one item carries down the pipeline
    typedef struct packed {
        logic        [2:0]        mode;
        logic        [15:0]       tag;
        logic signed [31:0]       sx;
        logic signed [31:0]       sy;
        logic signed [31:0]       offx;
        logic signed [31:0]       offy;
        logic signed [31:0]       sa;
        logic signed [31:0]       sb;
        logic signed [32:0]       dxw;
        logic signed [32:0]       dyw;
        logic signed [31:0]       dx;
        logic signed [31:0]       dy;
        logic [3:0][28:0]         tx;
        logic [3:0]               tneg;
        logic [3:0]               tone;
        logic [3:0]               tzero;
        logic [3:0][28:0]         tx2;
        logic [3:0][31:0]         tp;
        logic [3:0][29:0]         tv;   // 0 sin entity, 1 cos entity, 2 sin shape, 3 cos shape
        logic                     divx;
        logic                     divy;
        logic signed [63:0]       mxp;
        logic signed [63:0]       myp;
        logic        [63:0]       mra;
        logic        [63:0]       mrb;
        logic signed [63:0]       hw;
        logic signed [63:0]       hh;
        logic        [32:0]       abssum;
        logic signed [31:0]       mx;
        logic signed [31:0]       my;
        logic signed [31:0]       r;
        logic signed [31:0]       hl;
        logic [3:0][63:0]         rp;
        logic signed [31:0]       lx;
        logic signed [31:0]       ly;
        logic signed [31:0]       gx;
        logic signed [31:0]       gy;
        logic signed [31:0]       da;
        logic signed [31:0]       db;
        logic signed [31:0]       rr;
        logic                     rect;
        logic        [63:0]       sqa;
        logic        [63:0]       sqb;
        logic        [63:0]       sqr;
        logic                     hit_nd;
        logic        [31:0]       remx;
        logic        [31:0]       remy;
        logic        [31:0]       numx;
        logic        [31:0]       numy;
        logic        [31:0]       qx;
        logic        [31:0]       qy;
        logic        [31:0]       dvx;
        logic        [31:0]       dvy;
        logic                     ovfx;
        logic                     ovfy;
        logic                     negx;
        logic                     negy;
        logic                     hit;
    } t_pipe;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        if (v > 65'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -65'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] u;
        u = v;
        return u[31] ? (~u + 32'd1) : u;
    endfunction

    // |v| * (|sx| + |sy|) / 2, signed back and saturated
    function automatic logic signed [31:0] savg(input logic [63:0] m_in,
                                                input logic signed [31:0] v);
        logic [63:0]        m;
        logic signed [64:0] s;
        m = m_in >> (FRAC_BITS + 1);
        if (m > 64'h8000_0000) begin
            m = 64'h8000_0000;
        end
        s = $signed({1'b0, m});
        return sat32(v < 0 ? -s : s);
    endfunction

    // one restoring quotient bit: {bit, new remainder}
    function automatic logic [32:0] div_bit(input logic [31:0] rem, input logic nb,
                                            input logic [31:0] dv);
        logic [32:0] r33;
        logic        qb;
        r33 = {rem, nb};
        qb  = 1'b0;
        if (r33 >= {1'b0, dv}) begin
            r33 = r33 - {1'b0, dv};
            qb  = 1'b1;
        end
        return {qb, r33[31:0]};
    endfunction

    // truncated quotient, signed and saturated; g unchanged when en is low
    function automatic logic signed [31:0] grid_val(input logic signed [31:0] g,
                                                    input logic en, input logic [31:0] q,
                                                    input logic ovf, input logic neg);
        if (!en) begin
            return g;
        end
        if (!neg) begin
            return (ovf || q[31]) ? 32'sh7fffffff : $signed(q);
        end
        return (ovf || q > 32'h8000_0000) ? 32'sh80000000 : $signed(~q + 32'd1);
    endfunction

    logic signed [31:0] r_qx;
    logic signed [31:0] r_qy;
    t_pipe              r_s [1:NS];
    t_pipe              n_s [1:NS];
    logic [NS:1]        r_v;
    logic               w_en;

    // ---------------------------------------------------------------
    // Configuration: query point; the core does not enforce it, but it is to be written only while the core is idle
    // ---------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx <= '0;
            r_qy <= '0;
        end else if (i_cfg.valid) begin
            if (i_cfg.data.index == REG_QUERY_X) begin
                r_qx <= i_cfg.data.value;
            end else if (i_cfg.data.index == REG_QUERY_Y) begin
                r_qy <= i_cfg.data.value;
            end
        end
    end

    // ---------------------------------------------------------------
    // Flow control: the whole pipe advances unless the output holds a
    // result that the sink has not taken.  Bubbles travel as invalid.
    // ---------------------------------------------------------------
    assign w_en         = !r_v[NS] || o_res.ready;
    assign i_item.ready = w_en;

    // ---------------------------------------------------------------
    // Stage 1: offsets from the entity, angle folding into quarter turns,
    // absolute scale sum and the small-scale test of the grid kind.
    // ---------------------------------------------------------------
    logic [ANGLE_BITS-1:0] w_ang [4];
    logic [28:0]           w_x;

    always_comb begin
        n_s[1]        = '0;
        n_s[1].mode   = i_item.data.mode;
        n_s[1].tag    = i_item.data.entity_tag;
        n_s[1].sx     = i_item.data.scale_x;
        n_s[1].sy     = i_item.data.scale_y;
        n_s[1].offx   = i_item.data.offset_x;
        n_s[1].offy   = i_item.data.offset_y;
        n_s[1].sa     = i_item.data.size_a;
        n_s[1].sb     = i_item.data.size_b;
        n_s[1].dxw    = 33'(r_qx) - 33'(i_item.data.entity_x);
        n_s[1].dyw    = 33'(r_qy) - 33'(i_item.data.entity_y);
        n_s[1].dx     = sat32(65'(n_s[1].dxw));
        n_s[1].dy     = sat32(65'(n_s[1].dyw));
        n_s[1].abssum = 33'(mag32(i_item.data.scale_x)) + 33'(mag32(i_item.data.scale_y));
        n_s[1].divx   = (64'(mag32(i_item.data.scale_x)) * 64'd10000) > SMALL_LIM;
        n_s[1].divy   = (64'(mag32(i_item.data.scale_y)) * 64'd10000) > SMALL_LIM;
        // sine at the angle, cosine as sine a quarter turn on
        w_ang[0] = ANGLE_BITS'(i_item.data.entity_angle);
        w_ang[1] = w_ang[0] + QUARTER;
        w_ang[2] = ANGLE_BITS'(i_item.data.shape_angle);
        w_ang[3] = w_ang[2] + QUARTER;
        w_x      = '0;
        for (int k = 0; k < 4; k++) begin
            w_x = 29'(w_ang[k][QSH-1:0]) << XSH;
            if (w_ang[k][QSH]) begin
                w_x = TRIG_ONE - w_x;
            end
            n_s[1].tx[k]    = w_x;
            n_s[1].tneg[k]  = w_ang[k][QSH+1];
            n_s[1].tone[k]  = (w_x == TRIG_ONE);
            n_s[1].tzero[k] = (w_x == 29'd0);
        end
    end

    // ---------------------------------------------------------------
    // Stages 2..NS
    //   2      x^2, offset and size products
    //   3..7   sine polynomial (Horner), offsets and half extents settle
    //   8..9   rotation by the entity angle (forward for the circle)
    //  10      shape offset / circle centre, quotient set-up
    //  11..12  rotation by the shape angle
    //  13..15  capsule clamp, squared distances, shape hit
    //  11..42  grid quotient, one bit a stage per axis
    //  43      grid bounds, merge
    // ---------------------------------------------------------------
    for (genvar k = 2; k <= NS; k++) begin : g_stage
        t_pipe              w_n;
        logic signed [31:0] w_a;
        logic signed [31:0] w_b;
        logic signed [29:0] w_c;
        logic signed [29:0] w_sn;
        logic signed [32:0] w_cl;
        logic signed [63:0] w_v;
        logic [32:0]        w_dx;
        logic [32:0]        w_dy;

        always_comb begin
            w_n  = r_s[k-1];
            w_a  = '0;
            w_b  = '0;
            w_c  = '0;
            w_sn = '0;
            w_cl = '0;
            w_v  = '0;
            w_dx = '0;
            w_dy = '0;
            if (k == 2) begin
                for (int j = 0; j < 4; j++) begin
                    w_n.tx2[j] = 29'((58'(w_n.tx[j]) * 58'(w_n.tx[j])) >> TRIG_BITS);
                end
                w_n.mxp = 64'(w_n.offx) * 64'(w_n.sx);
                w_n.myp = 64'(w_n.offy) * 64'(w_n.sy);
                w_n.mra = 64'(mag32(w_n.sa)) * 64'(w_n.abssum);
                w_n.mrb = 64'(mag32(w_n.sb)) * 64'(w_n.abssum);
                // an image of no size takes the default extent
                w_a = (w_n.mode == MODE_IMAGE && w_n.sa <= 0) ? IMG_DEF : w_n.sa;
                w_b = (w_n.mode == MODE_IMAGE && w_n.sb <= 0) ? IMG_DEF : w_n.sb;
                w_n.hw = 64'(w_a) * 64'($signed({1'b0, mag32(w_n.sx)}));
                w_n.hh = 64'(w_b) * 64'($signed({1'b0, mag32(w_n.sy)}));
            end else if (k == 3) begin
                for (int j = 0; j < 4; j++) begin
                    w_n.tp[j] = 32'(-S_C7 + ((S_C9 * 64'($signed({1'b0, w_n.tx2[j]})))
                                             >>> TRIG_BITS));
                end
                w_n.mx = sat32(65'(w_n.mxp >>> FRAC_BITS));
                w_n.my = sat32(65'(w_n.myp >>> FRAC_BITS));
                w_n.r  = savg(w_n.mra, w_n.sa);
                w_n.hl = savg(w_n.mrb, w_n.sb);
                w_n.hw = w_n.hw >>> (FRAC_BITS + 1);
                w_n.hh = w_n.hh >>> (FRAC_BITS + 1);
            end else if (k >= 4 && k <= 6) begin
                w_v = (k == 4) ? S_C5 : ((k == 5) ? -S_C3 : S_C1);
                for (int j = 0; j < 4; j++) begin
                    w_n.tp[j] = 32'(w_v + ((64'($signed(w_n.tp[j]))
                                            * 64'($signed({1'b0, w_n.tx2[j]})))
                                           >>> TRIG_BITS));
                end
            end else if (k == 7) begin
                for (int j = 0; j < 4; j++) begin
                    w_v = (64'($signed(w_n.tp[j])) * 64'($signed({1'b0, w_n.tx[j]})))
                          >>> TRIG_BITS;
                    w_c = w_n.tone[j] ? 30'sd268435456 :
                          (w_n.tzero[j] ? 30'sd0 : 30'(w_v));
                    w_n.tv[j] = w_n.tneg[j] ? -w_c : w_c;
                end
            end else if (k == 8 || k == 11) begin
                if (k == 8) begin
                    // the circle turns its centre forward: negate the sine
                    w_a  = (w_n.mode == MODE_CIRCLE) ? w_n.mx : w_n.dx;
                    w_b  = (w_n.mode == MODE_CIRCLE) ? w_n.my : w_n.dy;
                    w_c  = $signed(w_n.tv[1]);
                    w_sn = (w_n.mode == MODE_CIRCLE) ? -$signed(w_n.tv[0])
                                                     : $signed(w_n.tv[0]);
                end else begin
                    w_a  = w_n.lx;
                    w_b  = w_n.ly;
                    w_c  = $signed(w_n.tv[3]);
                    w_sn = $signed(w_n.tv[2]);
                end
                w_n.rp[0] = 64'(w_a) * 64'(w_c);
                w_n.rp[1] = 64'(w_b) * 64'(w_sn);
                w_n.rp[2] = 64'(w_b) * 64'(w_c);
                w_n.rp[3] = 64'(w_a) * 64'(w_sn);
            end else if (k == 9 || k == 12) begin
                if (k == 9 || w_n.mode == MODE_BOX || w_n.mode == MODE_CAPS) begin
                    w_n.lx = sat32(65'(($signed(w_n.rp[0]) + $signed(w_n.rp[1]))
                                       >>> TRIG_BITS));
                    w_n.ly = sat32(65'(($signed(w_n.rp[2]) - $signed(w_n.rp[3]))
                                       >>> TRIG_BITS));
                end
                if (k == 9) begin
                    w_n.gx = w_n.lx;
                    w_n.gy = w_n.ly;
                end
            end else if (k == 10) begin
                case (w_n.mode)
                    MODE_BOX, MODE_CAPS: begin
                        w_n.lx = sat32(65'(w_n.lx) - 65'(w_n.mx));
                        w_n.ly = sat32(65'(w_n.ly) - 65'(w_n.my));
                    end
                    MODE_CIRCLE: begin
                        w_n.lx = sat32(65'(w_n.dxw) - 65'(w_n.lx));
                        w_n.ly = sat32(65'(w_n.dyw) - 65'(w_n.ly));
                    end
                    default: begin
                    end
                endcase
                // quotient set-up: (|g| << FRAC_BITS) / |scale|
                w_n.dvx  = mag32(w_n.sx);
                w_n.dvy  = mag32(w_n.sy);
                w_n.remx = mag32(w_n.gx) >> (32 - FRAC_BITS);
                w_n.remy = mag32(w_n.gy) >> (32 - FRAC_BITS);
                w_n.numx = mag32(w_n.gx) << FRAC_BITS;
                w_n.numy = mag32(w_n.gy) << FRAC_BITS;
                w_n.qx   = '0;
                w_n.qy   = '0;
                w_n.ovfx = w_n.remx >= w_n.dvx;
                w_n.ovfy = w_n.remy >= w_n.dvy;
                w_n.negx = w_n.gx[31] ^ w_n.sx[31];
                w_n.negy = w_n.gy[31] ^ w_n.sy[31];
            end else if (k == 13) begin
                // capsule: nearest point on the axis segment
                w_cl = 33'(w_n.ly);
                if (w_cl > 33'(w_n.hl)) begin
                    w_cl = 33'(w_n.hl);
                end
                if (w_cl < -33'(w_n.hl)) begin
                    w_cl = -33'(w_n.hl);
                end
                case (w_n.mode)
                    MODE_CIRCLE: begin
                        w_n.da = w_n.lx;
                        w_n.db = w_n.ly;
                        w_n.rr = w_n.r;
                    end
                    MODE_CAPS: begin
                        w_n.da = w_n.lx;
                        w_n.db = sat32(65'(w_n.ly) - 65'(w_cl));
                        w_n.rr = w_n.r;
                    end
                    default: begin
                        w_n.da = w_n.dx;
                        w_n.db = w_n.dy;
                        w_n.rr = w_n.sa;
                    end
                endcase
                w_n.rect = ($signed({32'b0, mag32(w_n.lx)}) <= w_n.hw) &&
                           ($signed({32'b0, mag32(w_n.ly)}) <= w_n.hh);
            end else if (k == 14) begin
                w_n.sqa = 64'(mag32(w_n.da)) * 64'(mag32(w_n.da));
                w_n.sqb = 64'(mag32(w_n.db)) * 64'(mag32(w_n.db));
                w_n.sqr = 64'(mag32(w_n.rr)) * 64'(mag32(w_n.rr));
            end else if (k == 15) begin
                case (w_n.mode)
                    MODE_BOX, MODE_IMAGE:
                        w_n.hit_nd = w_n.rect;
                    MODE_CIRCLE, MODE_CAPS, MODE_PROX:
                        w_n.hit_nd = (65'(w_n.sqa) + 65'(w_n.sqb)) <= 65'(w_n.sqr);
                    default:
                        w_n.hit_nd = 1'b0;
                endcase
            end else if (k == NS) begin
                w_a = grid_val(w_n.gx, w_n.divx, w_n.qx, w_n.ovfx, w_n.negx);
                w_b = grid_val(w_n.gy, w_n.divy, w_n.qy, w_n.ovfy, w_n.negy);
                if (w_n.mode == MODE_GRID) begin
                    w_n.hit = (w_n.sa > 0) && (w_n.sb > 0) &&
                              (34'(w_a) >= -34'(w_n.offx)) &&
                              (34'(w_a) <= 34'(w_n.sa) - 34'(w_n.offx)) &&
                              (34'(w_b) >= -34'(w_n.offy)) &&
                              (34'(w_b) <= 34'(w_n.sb) - 34'(w_n.offy));
                end else begin
                    w_n.hit = w_n.hit_nd;
                end
            end
            // grid quotient: advance one bit per axis
            if (k >= DIV_FIRST && k <= DIV_LAST) begin
                w_dx     = div_bit(w_n.remx, w_n.numx[31], w_n.dvx);
                w_dy     = div_bit(w_n.remy, w_n.numy[31], w_n.dvy);
                w_n.remx = w_dx[31:0];
                w_n.remy = w_dy[31:0];
                w_n.qx   = {w_n.qx[30:0], w_dx[32]};
                w_n.qy   = {w_n.qy[30:0], w_dy[32]};
                w_n.numx = {w_n.numx[30:0], 1'b0};
                w_n.numy = {w_n.numy[30:0], 1'b0};
            end
        end

        assign n_s[k] = w_n;
    end

    // ---------------------------------------------------------------
    // Stage registers: payload without reset, valid bits cleared
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 1; k <= NS; k++) begin
                r_s[k] <= n_s[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NS-1:1], i_item.valid};
        end
    end

    // result transaction straight from the last stage register
    assign o_res.valid           = r_v[NS];
    assign o_res.data.hit        = r_s[NS].hit;
    assign o_res.data.result_tag = r_s[NS].tag;

endmodule : point_in_oriented_shape_test_core

`default_nettype wire
